// ----- rtl/slr_pkg.sv -----
package slr_pkg;

  // Widths fixed by the channel fields.
  localparam int FIELD_W       = 16;
  localparam int WIDE_SAMPLE_W = 24;

  // Shift amounts for the rounded quotients and rounded square roots.
  localparam int RND_SHIFT = 17;
  localparam int R_SHIFT   = 62;
  localparam int T_SHIFT   = 34;

  localparam int MIN_PAIRS = 3;

  localparam logic [31:0] LIM_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] LIM_NEG = 32'h8000_0000;
  localparam logic [31:0] LIM_R   = 32'h4000_0000;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FEW  = 2'd1,
    STAT_FLAT = 2'd2
  } slr_status_e;

  typedef enum logic [2:0] {
    OP_MUL  = 3'b001,
    OP_DIV  = 3'b010,
    OP_SQRT = 3'b100
  } slr_op_e;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x_sample;
    logic signed [FIELD_W-1:0] y_sample;
    logic                      last_pair;
  } slr_in_t;

  typedef struct packed {
    logic signed [31:0] slope_out;
    logic signed [31:0] intercept_out;
    logic signed [31:0] r_value;
    logic signed [31:0] t_stat;
    logic [30:0]        std_error;
    logic [1:0]         status;
  } slr_out_t;

  typedef struct packed {
    logic    start;
    slr_op_e op;
  } slr_unit_req_t;

  typedef struct packed {
    logic start;
    logic clear;
  } slr_acc_ctl_t;

endpackage

// ----- rtl/slr_accum.sv -----
module slr_accum #(
  parameter int MAX_PAIRS   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  slr_pkg::slr_acc_ctl_t                      ctl,
  input  logic signed [SAMPLE_BITS-1:0]              x_in,
  input  logic signed [SAMPLE_BITS-1:0]              y_in,
  output logic                                       busy,
  output logic [$clog2(MAX_PAIRS+1)-1:0]             count,
  output logic signed [SAMPLE_BITS+$clog2(MAX_PAIRS+1)-1:0]   sum_x,
  output logic signed [SAMPLE_BITS+$clog2(MAX_PAIRS+1)-1:0]   sum_y,
  output logic signed [2*SAMPLE_BITS+$clog2(MAX_PAIRS+1)-1:0] sum_xx,
  output logic signed [2*SAMPLE_BITS+$clog2(MAX_PAIRS+1)-1:0] sum_yy,
  output logic signed [2*SAMPLE_BITS+$clog2(MAX_PAIRS+1)-1:0] sum_xy
);
  import slr_pkg::*;

  localparam int CW  = $clog2(MAX_PAIRS + 1);
  localparam int SXW = SAMPLE_BITS + CW;
  localparam int SQW = 2 * SAMPLE_BITS + CW;
  localparam int BCW = $clog2(SAMPLE_BITS + 1);

  logic [CW-1:0]          count_r;
  logic signed [SXW-1:0]  sx_r, sy_r;
  logic signed [SQW-1:0]  sxx_r, syy_r, sxy_r;
  logic signed [SQW-1:0]  mcx_r, mcy_r;
  logic [SAMPLE_BITS-1:0] xb_r, yb_r;
  logic [BCW-1:0]         bit_r;
  logic                   en_r, busy_r;

  logic                   last_bit;
  logic signed [SQW-1:0]  term_xx, term_yy, term_xy;

  // The top multiplier bit carries negative weight.
  always_comb begin
    last_bit = (bit_r == BCW'(1));
    term_xx  = '0;
    term_yy  = '0;
    term_xy  = '0;
    if (xb_r[0]) begin
      term_xx = last_bit ? -mcx_r : mcx_r;
    end
    if (yb_r[0]) begin
      term_yy = last_bit ? -mcy_r : mcy_r;
      term_xy = last_bit ? -mcx_r : mcx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sx_r    <= '0;
      sy_r    <= '0;
      sxx_r   <= '0;
      syy_r   <= '0;
      sxy_r   <= '0;
      busy_r  <= 1'b0;
      en_r    <= 1'b0;
      bit_r   <= '0;
    end else if (ctl.clear) begin
      count_r <= '0;
      sx_r    <= '0;
      sy_r    <= '0;
      sxx_r   <= '0;
      syy_r   <= '0;
      sxy_r   <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      bit_r  <= BCW'(SAMPLE_BITS);
      en_r   <= (count_r < CW'(MAX_PAIRS));
      mcx_r  <= SQW'(x_in);
      mcy_r  <= SQW'(y_in);
      xb_r   <= x_in;
      yb_r   <= y_in;
      if (count_r < CW'(MAX_PAIRS)) begin
        count_r <= count_r + CW'(1);
        sx_r    <= sx_r + SXW'(x_in);
        sy_r    <= sy_r + SXW'(y_in);
      end
    end else if (busy_r) begin
      if (en_r) begin
        sxx_r <= sxx_r + term_xx;
        syy_r <= syy_r + term_yy;
        sxy_r <= sxy_r + term_xy;
      end
      mcx_r <= mcx_r <<< 1;
      mcy_r <= mcy_r <<< 1;
      xb_r  <= xb_r >> 1;
      yb_r  <= yb_r >> 1;
      bit_r <= bit_r - BCW'(1);
      if (last_bit) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy   = busy_r;
  assign count  = count_r;
  assign sum_x  = sx_r;
  assign sum_y  = sy_r;
  assign sum_xx = sxx_r;
  assign sum_yy = syy_r;
  assign sum_xy = sxy_r;

endmodule

// ----- rtl/slr_serial_unit.sv -----
module slr_serial_unit #(
  parameter int WB = 198
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  slr_pkg::slr_unit_req_t req,
  input  logic [WB-1:0]         a_in,
  input  logic [WB-1:0]         b_in,
  output logic                  done,
  output logic [WB-1:0]         res
);
  import slr_pkg::*;

  localparam int CNTW = $clog2(WB + 1);

  logic [WB-1:0]   a_r, b_r;
  logic [WB+1:0]   acc_r;
  logic [CNTW-1:0] cnt_r;
  slr_op_e         op_r;
  logic            busy_r, done_r;

  logic [WB-1:0]   mul_sum;
  logic [WB:0]     div_sh, div_rem;
  logic            div_ge;
  logic [WB+1:0]   sq_sh, sq_trial, sq_rem;
  logic            sq_ge;

  always_comb begin
    mul_sum  = acc_r[WB-1:0] + a_r;
    div_sh   = {acc_r[WB-1:0], a_r[WB-1]};
    div_ge   = (div_sh >= {1'b0, b_r});
    div_rem  = div_sh - {1'b0, b_r};
    sq_sh    = {acc_r[WB-1:0], a_r[WB-1:WB-2]};
    sq_trial = {b_r, 2'b01};
    sq_ge    = (sq_sh >= sq_trial);
    sq_rem   = sq_sh - sq_trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= OP_MUL;
    end else if (req.start) begin
      a_r    <= a_in;
      b_r    <= (req.op == OP_SQRT) ? '0 : b_in;
      acc_r  <= '0;
      cnt_r  <= (req.op == OP_SQRT) ? CNTW'(WB / 2) : CNTW'(WB);
      op_r   <= req.op;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      case (op_r)
        OP_MUL: begin
          if (b_r[0]) begin
            acc_r <= {2'b00, mul_sum};
          end
          a_r <= a_r << 1;
          b_r <= b_r >> 1;
        end
        OP_DIV: begin
          acc_r <= div_ge ? {1'b0, div_rem} : {1'b0, div_sh};
          a_r   <= {a_r[WB-2:0], div_ge};
        end
        OP_SQRT: begin
          acc_r <= sq_ge ? sq_rem : sq_sh;
          b_r   <= {b_r[WB-2:0], sq_ge};
          a_r   <= a_r << 2;
        end
        default: begin
          acc_r <= acc_r;
        end
      endcase
      cnt_r <= cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_comb begin
    case (op_r)
      OP_MUL:  res = acc_r[WB-1:0];
      OP_DIV:  res = a_r;
      OP_SQRT: res = b_r;
      default: res = acc_r[WB-1:0];
    endcase
  end

  assign done = done_r;

endmodule

// ----- rtl/simple_linear_regression.sv -----
// Channel  Direction  Payload      Handshake
// in_      input      slr_in_t     in_valid / in_ready
// out_     output     slr_out_t    out_valid / out_ready
//
// Each sample pair is accepted and its samples added, then the bit-serial
// product adder works through the multiplier bits in turn, and then control
// hands back to idle before the next pair is taken.
// A pair with last_pair set is followed by the closing computation, which runs
// up to 14 multiplies, 5 divides and 3 square roots on the shared serial
// arithmetic unit, all of width WB (WB is 198 at the default parameters).
// Reset is synchronous and active low and clears all sums. A stalled result
// sits in the output register while the next series is already being accepted.
module simple_linear_regression #(
  parameter int MAX_PAIRS   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  slr_pkg::slr_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output slr_pkg::slr_out_t out_data
);
  import slr_pkg::*;

  // Count, linear-sum and square-sum widths follow from the parameters. The
  // spreads (n * sum of squares minus square of sum) need DW bits, and WB is
  // wide enough for every shifted product and quotient of the closing math.
  localparam int CW  = $clog2(MAX_PAIRS + 1);
  localparam int SXW = SAMPLE_BITS + CW;
  localparam int SQW = 2 * SAMPLE_BITS + CW;
  localparam int DW  = 2 * SAMPLE_BITS + 2 * CW + 2;
  localparam int WB  = 2 * DW + 2 * CW + 64;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ACC  = 4'b0010,
    ST_CALC = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  // Steps of the closing computation, in order.
  typedef enum logic [26:0] {
    S_LOAD   = 27'h0000001,
    S_NSXX   = 27'h0000002,
    S_SXSX   = 27'h0000004,
    S_CHKX   = 27'h0000008,
    S_NSYY   = 27'h0000010,
    S_SYSY   = 27'h0000020,
    S_NSXY   = 27'h0000040,
    S_SXSY   = 27'h0000080,
    S_SLOPE  = 27'h0000100,
    S_SYDX   = 27'h0000200,
    S_SXDXY  = 27'h0000400,
    S_NDX    = 27'h0000800,
    S_ICPT   = 27'h0001000,
    S_CHKY   = 27'h0002000,
    S_DXDY   = 27'h0004000,
    S_DXYSQ  = 27'h0008000,
    S_EXC    = 27'h0010000,
    S_RDIV   = 27'h0020000,
    S_RSQRT  = 27'h0040000,
    S_CHKE   = 27'h0080000,
    S_DOFSQ  = 27'h0100000,
    S_TDIV   = 27'h0200000,
    S_TSQRT  = 27'h0400000,
    S_DXDX   = 27'h0800000,
    S_DXDOF  = 27'h1000000,
    S_SEDIV  = 27'h2000000,
    S_SESQRT = 27'h4000000
  } step_t;

  state_t state_r;
  step_t  step_r;
  logic   last_r;
  logic   issued_r;

  // Samples: only the low SAMPLE_BITS bits of each field count. The field is
  // zero-extended first so that sample widths above the field width work.
  logic [WIDE_SAMPLE_W-1:0]      x_wide, y_wide;
  logic signed [SAMPLE_BITS-1:0] x_smp, y_smp;

  always_comb begin
    x_wide = WIDE_SAMPLE_W'($unsigned(in_data.x_sample));
    y_wide = WIDE_SAMPLE_W'($unsigned(in_data.y_sample));
    x_smp  = $signed(x_wide[SAMPLE_BITS-1:0]);
    y_smp  = $signed(y_wide[SAMPLE_BITS-1:0]);
  end

  // Accumulator of count and sums, with a bit-serial product adder.
  slr_acc_ctl_t          acc_ctl;
  logic                  acc_busy;
  logic [CW-1:0]         acc_count;
  logic signed [SXW-1:0] acc_sx, acc_sy;
  logic signed [SQW-1:0] acc_sxx, acc_syy, acc_sxy;
  logic                  in_fire, out_load;

  assign in_ready      = (state_r == ST_IDLE);
  assign in_fire       = in_valid && in_ready;
  assign out_load      = (state_r == ST_OUT) && (!out_valid || out_ready);
  assign acc_ctl.start = in_fire;
  assign acc_ctl.clear = out_load;

  slr_accum #(
    .MAX_PAIRS   (MAX_PAIRS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (acc_ctl),
    .x_in   (x_smp),
    .y_in   (y_smp),
    .busy   (acc_busy),
    .count  (acc_count),
    .sum_x  (acc_sx),
    .sum_y  (acc_sy),
    .sum_xx (acc_sxx),
    .sum_yy (acc_syy),
    .sum_xy (acc_sxy)
  );

  // The sums hold still during the closing computation, so they are read
  // straight from the accumulator, sign-extended to the working width.
  logic [WB-1:0] rn, rsx, rsy, rsxx, rsyy, rsxy, dof;

  always_comb begin
    rn   = WB'(acc_count);
    rsx  = WB'(acc_sx);
    rsy  = WB'(acc_sy);
    rsxx = WB'(acc_sxx);
    rsyy = WB'(acc_syy);
    rsxy = WB'(acc_sxy);
    dof  = rn - WB'(2);
  end

  // Working registers of the closing computation, all two's complement.
  logic [WB-1:0] dx_r, dy_r, dxy_r, t0_r, t1_r, prod_r, sqxy_r, exc_r;

  logic signed [31:0] slope_r, icpt_r, r_r, t_r;
  logic [30:0]        se_r;
  slr_status_e        status_r;

  function automatic logic [WB-1:0] mag(input logic [WB-1:0] v);
    return v[WB-1] ? (WB'(0) - v) : v;
  endfunction

  // Rounded square root: halve the root of four times the quotient.
  function automatic logic [WB-1:0] half_up(input logic [WB-1:0] v);
    return (v + WB'(1)) >> 1;
  endfunction

  // Apply a sign to a magnitude and saturate at the given limits.
  function automatic logic [31:0] put_s(input logic neg, input logic [WB-1:0] m,
                                        input logic [31:0] lneg,
                                        input logic [31:0] lpos);
    logic [31:0] v;
    if (neg) begin
      v = (m > WB'(lneg)) ? (32'd0 - lneg) : (32'd0 - m[31:0]);
    end else begin
      v = (m > WB'(lpos)) ? lpos : m[31:0];
    end
    return v;
  endfunction

  // Operand selection for the shared serial unit. Every multiply works modulo
  // 2^WB on sign-extended operands, which gives the exact signed product.
  slr_unit_req_t u_req;
  slr_op_e       u_op;
  logic          u_use;
  logic [WB-1:0] u_a, u_b, u_res, dxy_mag, t0_mag, rnd_m;
  logic          u_done;
  logic [31:0]   se_full;

  always_comb begin
    dxy_mag = mag(dxy_r);
    t0_mag  = mag(t0_r);
    u_use   = 1'b1;
    u_op    = OP_MUL;
    u_a     = '0;
    u_b     = '0;
    case (step_r)
      S_NSXX:   begin u_a = rn;   u_b = rsxx; end
      S_SXSX:   begin u_a = rsx;  u_b = rsx;  end
      S_NSYY:   begin u_a = rn;   u_b = rsyy; end
      S_SYSY:   begin u_a = rsy;  u_b = rsy;  end
      S_NSXY:   begin u_a = rn;   u_b = rsxy; end
      S_SXSY:   begin u_a = rsx;  u_b = rsy;  end
      S_SLOPE: begin
        u_op = OP_DIV;
        u_a  = (dxy_mag << RND_SHIFT) + dx_r;
        u_b  = dx_r << 1;
      end
      S_SYDX:   begin u_a = rsy;  u_b = dx_r;  end
      S_SXDXY:  begin u_a = rsx;  u_b = dxy_r; end
      S_NDX:    begin u_a = rn;   u_b = dx_r;  end
      S_ICPT: begin
        u_op = OP_DIV;
        u_a  = (t0_mag << RND_SHIFT) + t1_r;
        u_b  = t1_r << 1;
      end
      S_DXDY:   begin u_a = dx_r;  u_b = dy_r;  end
      S_DXYSQ:  begin u_a = dxy_r; u_b = dxy_r; end
      S_RDIV:   begin u_op = OP_DIV;  u_a = sqxy_r << R_SHIFT; u_b = prod_r; end
      S_RSQRT:  begin u_op = OP_SQRT; u_a = t0_r; end
      S_DOFSQ:  begin u_a = dof;  u_b = sqxy_r; end
      S_TDIV:   begin u_op = OP_DIV;  u_a = t0_r << T_SHIFT; u_b = exc_r; end
      S_TSQRT:  begin u_op = OP_SQRT; u_a = t0_r; end
      S_DXDX:   begin u_a = dx_r; u_b = dx_r; end
      S_DXDOF:  begin u_a = t0_r; u_b = dof;  end
      S_SEDIV:  begin u_op = OP_DIV;  u_a = exc_r << T_SHIFT; u_b = t0_r; end
      S_SESQRT: begin u_op = OP_SQRT; u_a = t0_r; end
      default:  u_use = 1'b0;
    endcase
    u_req.start = (state_r == ST_CALC) && u_use && !issued_r;
    u_req.op    = u_op;
  end

  slr_serial_unit #(
    .WB (WB)
  ) u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (u_req),
    .a_in  (u_a),
    .b_in  (u_b),
    .done  (u_done),
    .res   (u_res)
  );

  assign rnd_m   = half_up(u_res);
  assign se_full = put_s(1'b0, rnd_m, LIM_POS, LIM_POS);

  // Main control. Unit steps issue once, then write back on the done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      step_r   <= S_LOAD;
      issued_r <= 1'b0;
      last_r   <= 1'b0;
      status_r <= STAT_OK;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            last_r  <= in_data.last_pair;
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (!acc_busy) begin
            state_r <= last_r ? ST_CALC : ST_IDLE;
            step_r  <= S_LOAD;
          end
        end
        ST_CALC: begin
          if (u_req.start) begin
            issued_r <= 1'b1;
          end
          if (u_done && issued_r) begin
            issued_r <= 1'b0;
          end
          case (step_r)
            S_LOAD: begin
              slope_r  <= '0;
              icpt_r   <= '0;
              r_r      <= '0;
              t_r      <= '0;
              se_r     <= '0;
              status_r <= STAT_OK;
              if (acc_count < CW'(MIN_PAIRS)) begin
                status_r <= STAT_FEW;
                state_r  <= ST_OUT;
              end else begin
                step_r <= S_NSXX;
              end
            end
            S_CHKX: begin
              if (dx_r == '0) begin
                status_r <= STAT_FLAT;
                state_r  <= ST_OUT;
              end else begin
                step_r <= S_NSYY;
              end
            end
            S_CHKY: begin
              // Constant y leaves r, t and the standard error at zero.
              if (dy_r == '0) begin
                state_r <= ST_OUT;
              end else begin
                step_r <= S_DXDY;
              end
            end
            S_EXC: begin
              exc_r  <= prod_r - sqxy_r;
              step_r <= S_RDIV;
            end
            S_CHKE: begin
              // A perfect fit drives t to full scale with the sign of r.
              if (exc_r == '0) begin
                t_r    <= dxy_r[WB-1] ? LIM_NEG : LIM_POS;
                step_r <= S_DXDX;
              end else begin
                step_r <= S_DOFSQ;
              end
            end
            default: begin
              if (u_done && issued_r) begin
                case (step_r)
                  S_NSXX:  begin t0_r <= u_res;          step_r <= S_SXSX;  end
                  S_SXSX:  begin dx_r <= t0_r - u_res;   step_r <= S_CHKX;  end
                  S_NSYY:  begin t0_r <= u_res;          step_r <= S_SYSY;  end
                  S_SYSY:  begin dy_r <= t0_r - u_res;   step_r <= S_NSXY;  end
                  S_NSXY:  begin t0_r <= u_res;          step_r <= S_SXSY;  end
                  S_SXSY:  begin dxy_r <= t0_r - u_res;  step_r <= S_SLOPE; end
                  S_SLOPE: begin
                    slope_r <= put_s(dxy_r[WB-1], u_res, LIM_NEG, LIM_POS);
                    step_r  <= S_SYDX;
                  end
                  S_SYDX:  begin t0_r <= u_res;          step_r <= S_SXDXY; end
                  S_SXDXY: begin t0_r <= t0_r - u_res;   step_r <= S_NDX;   end
                  S_NDX:   begin t1_r <= u_res;          step_r <= S_ICPT;  end
                  S_ICPT: begin
                    icpt_r <= put_s(t0_r[WB-1], u_res, LIM_NEG, LIM_POS);
                    step_r <= S_CHKY;
                  end
                  S_DXDY:  begin prod_r <= u_res;        step_r <= S_DXYSQ; end
                  S_DXYSQ: begin sqxy_r <= u_res;        step_r <= S_EXC;   end
                  S_RDIV:  begin t0_r <= u_res;          step_r <= S_RSQRT; end
                  S_RSQRT: begin
                    r_r    <= put_s(dxy_r[WB-1], rnd_m, LIM_R, LIM_R);
                    step_r <= S_CHKE;
                  end
                  S_DOFSQ: begin t0_r <= u_res;          step_r <= S_TDIV;  end
                  S_TDIV:  begin t0_r <= u_res;          step_r <= S_TSQRT; end
                  S_TSQRT: begin
                    t_r    <= put_s(dxy_r[WB-1], rnd_m, LIM_NEG, LIM_POS);
                    step_r <= S_DXDX;
                  end
                  S_DXDX:  begin t0_r <= u_res;          step_r <= S_DXDOF; end
                  S_DXDOF: begin t0_r <= u_res;          step_r <= S_SEDIV; end
                  S_SEDIV: begin t0_r <= u_res;          step_r <= S_SESQRT; end
                  S_SESQRT: begin
                    se_r    <= se_full[30:0];
                    state_r <= ST_OUT;
                  end
                  default: begin
                    state_r <= ST_OUT;
                  end
                endcase
              end
            end
          endcase
        end
        ST_OUT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: a finished result waits here without holding up input.
  logic     out_valid_r;
  slr_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.slope_out     <= slope_r;
      out_data_r.intercept_out <= icpt_r;
      out_data_r.r_value       <= r_r;
      out_data_r.t_stat        <= t_r;
      out_data_r.std_error     <= se_r;
      out_data_r.status        <= status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/slr_checker.sv -----
module slr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input slr_pkg::slr_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input slr_pkg::slr_out_t out_data
);
  import slr_pkg::*;

  // A held result must not change until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // After a request is taken the block works on it before taking another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken back to back");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == STAT_OK || out_data.status == STAT_FEW ||
                   out_data.status == STAT_FLAT))
    else $error("undefined status code");

  // An error status comes with all numeric fields cleared.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STAT_OK |->
      out_data.slope_out == 0 && out_data.intercept_out == 0 &&
      out_data.r_value == 0 && out_data.t_stat == 0 && out_data.std_error == 0)
    else $error("nonzero field with error status");

  a_r_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.r_value <= 32'sh4000_0000 &&
                  out_data.r_value >= -32'sh4000_0000)
    else $error("correlation out of range");

endmodule

bind simple_linear_regression slr_checker u_slr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
